// File: hdl/track_haversine_distance_accumulator_unit_assert.svh
// assertion macros used by the checker
`ifndef TRACK_HAVERSINE_DISTANCE_ACCUMULATOR_UNIT_ASSERT_SVH
`define TRACK_HAVERSINE_DISTANCE_ACCUMULATOR_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define THDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define THDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/thda_pkg.sv
package thda_pkg;

	localparam int LON_W = 25;
	localparam int LAT_W = 24;
	localparam int LEG_W = 25;
	localparam int TOT_W = 32;
	localparam int RAD_W = 23;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int ITER_W = 5;
	localparam int SQRT_STEPS = 31;

	localparam int QUEUE_DEPTH = 2;

	// datapath width of the cordic and multiplier operands
	localparam int CW = 34;
	localparam int ANG_W = 27;
	localparam int SQ_W = 62;
	localparam int REM_W = 61;
	localparam int A_W = 31;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd6378137;

	localparam logic signed [ANG_W-1:0] FULL_TURN = 27'sd47185920;
	localparam logic signed [ANG_W-1:0] HALF_TURN = 27'sd23592960;
	localparam logic signed [ANG_W-1:0] NEG_HALF_TURN = -27'sd23592960;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 27'sd11796480;
	localparam logic signed [ANG_W-1:0] NEG_QUARTER_TURN = -27'sd11796480;

	localparam logic signed [CW-1:0] DEG_TO_RAD = 34'sd18740330;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW:0] ONE_Q30 = 35'sd1073741824;
	localparam logic [A_W-1:0] ONE_A = 31'h40000000;

	localparam logic [LEG_W-1:0] LEG_MAX = 25'h1FFFFFF;
	localparam logic [TOT_W-1:0] TOT_MAX = 32'hFFFFFFFF;

	typedef struct packed {
		logic signed [LON_W-1:0] lon;
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] plon;
		logic signed [LAT_W-1:0] plat;
		logic first;
		logic signed [LON_W-1:0] mid_lon;
		logic signed [LAT_W-1:0] mid_lat;
	} cmd_t;

	function automatic logic signed [CW-1:0] atan_q30(input logic [ITER_W-1:0] idx);
		logic signed [CW-1:0] r;
		case (idx)
			5'd0: r = 34'sd843314856;
			5'd1: r = 34'sd497837829;
			5'd2: r = 34'sd263043836;
			5'd3: r = 34'sd133525158;
			5'd4: r = 34'sd67021686;
			5'd5: r = 34'sd33543515;
			5'd6: r = 34'sd16775850;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194282;
			5'd9: r = 34'sd2097149;
			5'd10: r = 34'sd1048575;
			5'd11: r = 34'sd524287;
			5'd12: r = 34'sd262143;
			5'd13: r = 34'sd131071;
			5'd14: r = 34'sd65535;
			5'd15: r = 34'sd32767;
			5'd16: r = 34'sd16383;
			5'd17: r = 34'sd8191;
			5'd18: r = 34'sd4095;
			5'd19: r = 34'sd2047;
			5'd20: r = 34'sd1023;
			5'd21: r = 34'sd511;
			5'd22: r = 34'sd255;
			5'd23: r = 34'sd127;
			5'd24: r = 34'sd63;
			5'd25: r = 34'sd31;
			5'd26: r = 34'sd15;
			5'd27: r = 34'sd7;
			5'd28: r = 34'sd3;
			5'd29: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/thda_front.sv
module thda_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [thda_pkg::LON_W-1:0] lon_deg,
	input  logic signed [thda_pkg::LAT_W-1:0] lat_deg,
	input  logic track_start,
	input  logic q_full,
	output logic push_valid,
	output thda_pkg::cmd_t push_cmd
);

	logic signed [thda_pkg::LON_W-1:0] prev_lon_q;
	logic signed [thda_pkg::LAT_W-1:0] prev_lat_q;
	logic have_prev_q;
	logic first;
	logic signed [thda_pkg::LON_W:0] sum_lon;
	logic signed [thda_pkg::LAT_W:0] sum_lat;

	assign in_stall = q_full;
	assign push_valid = in_valid && !q_full;
	assign first = track_start || !have_prev_q;

	assign sum_lon = {lon_deg[thda_pkg::LON_W-1], lon_deg}
		+ {prev_lon_q[thda_pkg::LON_W-1], prev_lon_q};
	assign sum_lat = {lat_deg[thda_pkg::LAT_W-1], lat_deg}
		+ {prev_lat_q[thda_pkg::LAT_W-1], prev_lat_q};

	always_comb begin
		push_cmd.lon = lon_deg;
		push_cmd.lat = lat_deg;
		push_cmd.plon = prev_lon_q;
		push_cmd.plat = prev_lat_q;
		push_cmd.first = first;
		// floor of the half sum is the upper bits of the sum
		push_cmd.mid_lon = first ? lon_deg : sum_lon[thda_pkg::LON_W:1];
		push_cmd.mid_lat = first ? lat_deg : sum_lat[thda_pkg::LAT_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_lon_q <= '0;
			prev_lat_q <= '0;
			have_prev_q <= 1'b0;
		end else if (push_valid) begin
			prev_lon_q <= lon_deg;
			prev_lat_q <= lat_deg;
			have_prev_q <= 1'b1;
		end
	end

endmodule

// File: hdl/thda_queue.sv
module thda_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  thda_pkg::cmd_t push_cmd,
	output logic q_full,
	input  logic q_pop,
	output logic q_valid,
	output thda_pkg::cmd_t q_cmd
);

	localparam int PW = $clog2(thda_pkg::QUEUE_DEPTH);

	thda_pkg::cmd_t mem_q [thda_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] cnt_q;
	logic push;
	logic pop;

	assign q_full = cnt_q == (PW+1)'(thda_pkg::QUEUE_DEPTH);
	assign q_valid = cnt_q != '0;
	assign q_cmd = mem_q[rd_ptr_q];
	assign push = push_valid && !q_full;
	assign pop = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/thda_back.sv
module thda_back #(
	parameter int CORDIC_STEPS = thda_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [thda_pkg::RAD_W-1:0] radius,
	input  logic q_valid,
	input  thda_pkg::cmd_t q_cmd,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [thda_pkg::LEG_W-1:0] leg_distance_m,
	output logic [thda_pkg::TOT_W-1:0] total_distance_m,
	output logic signed [thda_pkg::LON_W-1:0] mid_lon_deg,
	output logic signed [thda_pkg::LAT_W-1:0] mid_lat_deg,
	output logic total_saturated
);

	localparam int CW = thda_pkg::CW;
	localparam logic [thda_pkg::ITER_W-1:0] ROT_LAST = thda_pkg::ITER_W'(CORDIC_STEPS - 1);
	localparam logic [thda_pkg::ITER_W-1:0] SQRT_LAST =
		thda_pkg::ITER_W'(thda_pkg::SQRT_STEPS - 1);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_PREP  = 10'b0000000010,
		S_ROT   = 10'b0000000100,
		S_STORE = 10'b0000001000,
		S_MUL   = 10'b0000010000,
		S_SQRT  = 10'b0000100000,
		S_VINIT = 10'b0001000000,
		S_VEC   = 10'b0010000000,
		S_SCALE = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;
	thda_pkg::cmd_t cmd_q;
	logic [1:0] k_q;
	logic [1:0] mstep_q;
	logic [thda_pkg::ITER_W-1:0] iter_q;
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic neg_q;
	logic signed [CW-1:0] s1_q, s2_q, ca_q, cb_q;
	logic signed [CW-1:0] h1_q, h2_q, cc_q;
	logic [thda_pkg::REM_W-1:0] rx_q, ry_q;
	logic [thda_pkg::SQ_W-1:0] resx_q, resy_q;
	logic [thda_pkg::REM_W-1:0] bit_q;
	logic [thda_pkg::LEG_W-1:0] leg_q;
	logic [thda_pkg::TOT_W-1:0] total_q;
	logic out_valid_q;
	logic [thda_pkg::LEG_W-1:0] leg_out_q;
	logic [thda_pkg::TOT_W-1:0] tot_out_q;
	logic signed [thda_pkg::LON_W-1:0] mlon_out_q;
	logic signed [thda_pkg::LAT_W-1:0] mlat_out_q;

	// angle selection and reduction
	logic signed [thda_pkg::ANG_W-1:0] ang, ang_w, ang_f;
	logic fold_neg;

	always_comb begin
		case (k_q)
			2'd0: ang = {{3{cmd_q.lat[thda_pkg::LAT_W-1]}}, cmd_q.lat}
				- {{3{cmd_q.plat[thda_pkg::LAT_W-1]}}, cmd_q.plat};
			2'd1: ang = {{2{cmd_q.lon[thda_pkg::LON_W-1]}}, cmd_q.lon}
				- {{2{cmd_q.plon[thda_pkg::LON_W-1]}}, cmd_q.plon};
			2'd2: ang = {{2{cmd_q.lat[thda_pkg::LAT_W-1]}}, cmd_q.lat, 1'b0};
			default: ang = {{2{cmd_q.plat[thda_pkg::LAT_W-1]}}, cmd_q.plat, 1'b0};
		endcase
		if (ang >= thda_pkg::HALF_TURN) begin
			ang_w = ang - thda_pkg::FULL_TURN;
		end else if (ang < thda_pkg::NEG_HALF_TURN) begin
			ang_w = ang + thda_pkg::FULL_TURN;
		end else begin
			ang_w = ang;
		end
		// fold into the right half plane, sine and cosine change sign
		if (ang_w > thda_pkg::QUARTER_TURN) begin
			ang_f = ang_w - thda_pkg::HALF_TURN;
			fold_neg = 1'b1;
		end else if (ang_w < thda_pkg::NEG_QUARTER_TURN) begin
			ang_f = ang_w + thda_pkg::HALF_TURN;
			fold_neg = 1'b1;
		end else begin
			ang_f = ang_w;
			fold_neg = 1'b0;
		end
	end

	// shared multiplier
	logic signed [CW-1:0] mul_a, mul_b;
	logic signed [2*CW-1:0] prod;
	logic signed [CW-1:0] zc;

	assign zc = cz_q[CW-1] ? '0 : cz_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_PREP: begin
				mul_a = {{(CW-thda_pkg::ANG_W){ang_f[thda_pkg::ANG_W-1]}}, ang_f};
				mul_b = thda_pkg::DEG_TO_RAD;
			end
			S_MUL: begin
				case (mstep_q)
					2'd0: begin
						mul_a = s1_q;
						mul_b = s1_q;
					end
					2'd1: begin
						mul_a = s2_q;
						mul_b = s2_q;
					end
					2'd2: begin
						mul_a = ca_q;
						mul_b = cb_q;
					end
					default: begin
						mul_a = cc_q;
						mul_b = h2_q;
					end
				endcase
			end
			S_SCALE: begin
				mul_a = {{(CW-thda_pkg::RAD_W){1'b0}}, radius};
				mul_b = zc;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// haversine term from the last product, clamped to [0, 1]
	logic signed [CW:0] a_sum;
	logic [thda_pkg::A_W-1:0] a_n;

	always_comb begin
		a_sum = {h1_q[CW-1], h1_q} + {prod[63], prod[63:30]};
		if (a_sum[CW]) begin
			a_n = '0;
		end else if (a_sum > thda_pkg::ONE_Q30) begin
			a_n = thda_pkg::ONE_A;
		end else begin
			a_n = a_sum[thda_pkg::A_W-1:0];
		end
	end

	// rounded radius scaling
	logic [55:0] rnd;
	logic [26:0] leg_raw;
	logic [thda_pkg::LEG_W-1:0] leg_n;

	assign rnd = {1'b0, prod[54:0]} + 56'h0000000_10000000;
	assign leg_raw = rnd[55:29];
	assign leg_n = (leg_raw > {2'b00, thda_pkg::LEG_MAX}) ? thda_pkg::LEG_MAX
		: leg_raw[thda_pkg::LEG_W-1:0];

	// cordic micro-rotation, rotation or vectoring
	logic signed [CW-1:0] dx, dy, at, nx, ny, nz;
	logic dir;

	always_comb begin
		dx = cy_q >>> iter_q;
		dy = cx_q >>> iter_q;
		at = thda_pkg::atan_q30(iter_q);
		dir = (state_q == S_VEC) ? cy_q[CW-1] : !cz_q[CW-1];
		if (dir) begin
			nx = cx_q - dx;
			ny = cy_q + dy;
			nz = cz_q - at;
		end else begin
			nx = cx_q + dx;
			ny = cy_q - dy;
			nz = cz_q + at;
		end
	end

	// one result bit per cycle for both square roots
	logic [thda_pkg::SQ_W-1:0] trial_x, trial_y, resx_n, resy_n;
	logic [thda_pkg::REM_W-1:0] rx_n, ry_n;

	always_comb begin
		trial_x = resx_q + {1'b0, bit_q};
		trial_y = resy_q + {1'b0, bit_q};
		if ({1'b0, rx_q} >= trial_x) begin
			rx_n = rx_q - trial_x[thda_pkg::REM_W-1:0];
			resx_n = (resx_q >> 1) + {1'b0, bit_q};
		end else begin
			rx_n = rx_q;
			resx_n = resx_q >> 1;
		end
		if ({1'b0, ry_q} >= trial_y) begin
			ry_n = ry_q - trial_y[thda_pkg::REM_W-1:0];
			resy_n = (resy_q >> 1) + {1'b0, bit_q};
		end else begin
			ry_n = ry_q;
			resy_n = resy_q >> 1;
		end
	end

	// running total for the word in the done state
	logic [thda_pkg::TOT_W:0] tot_sum;
	logic [thda_pkg::TOT_W-1:0] tot_n;
	logic out_load;

	assign tot_sum = {1'b0, total_q} + {{(thda_pkg::TOT_W+1-thda_pkg::LEG_W){1'b0}}, leg_q};
	assign tot_n = cmd_q.first ? '0
		: (tot_sum[thda_pkg::TOT_W] ? thda_pkg::TOT_MAX : tot_sum[thda_pkg::TOT_W-1:0]);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			total_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				total_q <= tot_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= q_cmd.first ? S_DONE : S_PREP;
					end
				end
				S_PREP: state_q <= S_ROT;
				S_ROT: begin
					if (iter_q == ROT_LAST) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: state_q <= (k_q == 2'd3) ? S_MUL : S_PREP;
				S_MUL: begin
					if (mstep_q == 2'd3) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (iter_q == SQRT_LAST) begin
						state_q <= S_VINIT;
					end
				end
				S_VINIT: state_q <= S_VEC;
				S_VEC: begin
					if (iter_q == ROT_LAST) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			leg_out_q <= leg_q;
			tot_out_q <= tot_n;
			mlon_out_q <= cmd_q.mid_lon;
			mlat_out_q <= cmd_q.mid_lat;
		end
		case (state_q)
			S_IDLE: begin
				cmd_q <= q_cmd;
				k_q <= 2'd0;
				leg_q <= '0;
			end
			S_PREP: begin
				cx_q <= thda_pkg::CORDIC_GAIN;
				cy_q <= '0;
				cz_q <= prod[50:17];
				neg_q <= fold_neg;
				iter_q <= '0;
			end
			S_ROT, S_VEC: begin
				cx_q <= nx;
				cy_q <= ny;
				cz_q <= nz;
				iter_q <= iter_q + 1'b1;
			end
			S_STORE: begin
				case (k_q)
					2'd0: s1_q <= neg_q ? -cy_q : cy_q;
					2'd1: s2_q <= neg_q ? -cy_q : cy_q;
					2'd2: ca_q <= neg_q ? -cx_q : cx_q;
					default: cb_q <= neg_q ? -cx_q : cx_q;
				endcase
				k_q <= k_q + 1'b1;
				mstep_q <= 2'd0;
			end
			S_MUL: begin
				case (mstep_q)
					2'd0: h1_q <= prod[63:30];
					2'd1: h2_q <= prod[63:30];
					2'd2: cc_q <= prod[63:30];
					default: begin
						ry_q <= {a_n, 30'b0};
						rx_q <= {thda_pkg::ONE_A - a_n, 30'b0};
						resx_q <= '0;
						resy_q <= '0;
						bit_q <= {1'b1, {(thda_pkg::REM_W-1){1'b0}}};
						iter_q <= '0;
					end
				endcase
				mstep_q <= mstep_q + 1'b1;
			end
			S_SQRT: begin
				rx_q <= rx_n;
				ry_q <= ry_n;
				resx_q <= resx_n;
				resy_q <= resy_n;
				bit_q <= bit_q >> 2;
				iter_q <= iter_q + 1'b1;
			end
			S_VINIT: begin
				cx_q <= {{(CW-thda_pkg::A_W){1'b0}}, resx_q[thda_pkg::A_W-1:0]};
				cy_q <= {{(CW-thda_pkg::A_W){1'b0}}, resy_q[thda_pkg::A_W-1:0]};
				cz_q <= '0;
				iter_q <= '0;
			end
			S_SCALE: leg_q <= leg_n;
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign leg_distance_m = leg_out_q;
	assign total_distance_m = tot_out_q;
	assign mid_lon_deg = mlon_out_q;
	assign mid_lat_deg = mlat_out_q;
	assign total_saturated = tot_out_q == thda_pkg::TOT_MAX;

endmodule

// File: hdl/track_haversine_distance_accumulator_unit.sv
// channel   | handshake                 | payload
// ----------+---------------------------+--------------------------------------------
// input     | in_valid / in_stall       | lon_deg, lat_deg, track_start
// output    | out_valid / out_stall     | leg_distance_m, total_distance_m,
//           |                           | mid_lon_deg, mid_lat_deg, total_saturated
// config    | cfg_wr_en                 | cfg_wr_data (earth radius in meters)
//
// a leg in the back end takes four sin/cos runs and one atan2 run of the shared
// cordic unit and 31 square root steps
// a track start waypoint skips the leg computation
// a two-word queue lets the front take waypoints while the back end works
// async active-low reset; radius resets to 6378137 m, running total to zero
// a stalled output word holds the back end in its final state
module track_haversine_distance_accumulator_unit #(
	parameter int CORDIC_STEPS = thda_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [thda_pkg::RAD_W-1:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [thda_pkg::LON_W-1:0] lon_deg,
	input  logic signed [thda_pkg::LAT_W-1:0] lat_deg,
	input  logic track_start,
	output logic out_valid,
	input  logic out_stall,
	output logic [thda_pkg::LEG_W-1:0] leg_distance_m,
	output logic [thda_pkg::TOT_W-1:0] total_distance_m,
	output logic signed [thda_pkg::LON_W-1:0] mid_lon_deg,
	output logic signed [thda_pkg::LAT_W-1:0] mid_lat_deg,
	output logic total_saturated
);

	logic [thda_pkg::RAD_W-1:0] radius_q;
	logic push_valid;
	thda_pkg::cmd_t push_cmd;
	logic q_full;
	logic q_pop;
	logic q_valid;
	thda_pkg::cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= thda_pkg::RADIUS_RESET;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	thda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.lon_deg    (lon_deg),
		.lat_deg    (lat_deg),
		.track_start(track_start),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_cmd   (push_cmd)
	);

	thda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_cmd  (push_cmd),
		.q_full    (q_full),
		.q_pop     (q_pop),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd)
	);

	thda_back #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.radius          (radius_q),
		.q_valid         (q_valid),
		.q_cmd           (q_cmd),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.leg_distance_m  (leg_distance_m),
		.total_distance_m(total_distance_m),
		.mid_lon_deg     (mid_lon_deg),
		.mid_lat_deg     (mid_lat_deg),
		.total_saturated (total_saturated)
	);

endmodule

// File: hdl/thda_checker.sv
`include "track_haversine_distance_accumulator_unit_assert.svh"

module thda_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [thda_pkg::LEG_W-1:0] leg_distance_m,
	input logic [thda_pkg::TOT_W-1:0] total_distance_m,
	input logic signed [thda_pkg::LON_W-1:0] mid_lon_deg,
	input logic total_saturated
);

	`THDA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "word dropped")
	`THDA_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(leg_distance_m) && $stable(total_distance_m) && $stable(mid_lon_deg), "word changed while stalled")
	`THDA_ASSERT_SAME(a_sat_flag, clk, arst_n, out_valid, total_saturated == (total_distance_m == thda_pkg::TOT_MAX), "saturation flag mismatch")
	`THDA_ASSERT_SAME(a_leg_in_total, clk, arst_n, out_valid, 32'(leg_distance_m) <= total_distance_m, "leg exceeds total")

endmodule

bind track_haversine_distance_accumulator_unit thda_checker u_thda_checker (.*);
